// File: rtl/core/swdf_pkg.sv
package swdf_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int MAX_WORDS           = 30;
    localparam int CMD_OFFSET          = 2;
    localparam int PAYLOAD_OFFSET      = 3;
    localparam int MIN_FRAME_BYTES     = 4;

    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_XOR   = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_TOO_SHORT = 2'd3
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [4:0] words;
        logic       bank;
    } t_desc;

endpackage

// File: rtl/core/swdf_store.sv
module swdf_store #(
    parameter int MAX_FRAME_BYTES = swdf_pkg::MAX_FRAME_BYTES_DEF,
    parameter int AW              = $clog2(MAX_FRAME_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW:0]   i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW:0]   i_rd_addr,
    output logic [7:0]    o_rd_data
);
    localparam int DEPTH = 2 ** (AW + 1);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/swdf_front.sv
module swdf_front #(
    parameter int MAX_FRAME_BYTES = swdf_pkg::MAX_FRAME_BYTES_DEF,
    parameter int AW              = $clog2(MAX_FRAME_BYTES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_back_busy,
    output logic                 o_wr_en,
    output logic [AW:0]          o_wr_addr,
    output logic [7:0]           o_wr_data,
    output logic                 o_q_valid,
    output swdf_pkg::t_desc      o_q_desc,
    input  logic                 i_q_pop
);
    import swdf_pkg::*;

    localparam int LW = $clog2(MAX_FRAME_BYTES + 1);

    logic [7:0]    r_sync_first, r_sync_second;
    logic [7:0]    r_held, n_held;
    logic          r_held_valid, n_held_valid;
    logic          r_in_frame, n_in_frame;
    logic [LW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_xor, n_xor;
    logic          r_bank, n_bank;
    logic          r_q_valid, n_q_valid;
    t_desc         r_q_desc, n_q_desc;

    logic          accept;
    logic          push;
    logic          wr_bank;
    logic [LW:0]   diff;
    logic [LW-1:0] half;
    t_status       status;
    logic [4:0]    words;

    assign o_ready   = !(r_held_valid && r_in_frame && (r_held == r_sync_first)
                         && (i_back_busy || r_q_valid));
    assign accept    = i_valid && o_ready;
    assign o_q_valid = r_q_valid;
    assign o_q_desc  = r_q_desc;

    always_comb begin
        diff = {1'b0, r_len} - (LW + 1)'(MIN_FRAME_BYTES);
        half = diff[LW:1];
        if (int'(half) > MAX_WORDS) begin
            words = 5'(MAX_WORDS);
        end else begin
            words = 5'(half);
        end
        if (r_ovf) begin
            status = ST_TOO_LONG;
        end else if (r_len < LW'(MIN_FRAME_BYTES)) begin
            status = ST_TOO_SHORT;
        end else if (r_xor != 8'd0) begin
            status = ST_BAD_XOR;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_in_frame   = r_in_frame;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_xor        = r_xor;
        n_bank       = r_bank;
        push         = 1'b0;
        wr_bank      = r_bank;
        o_wr_en      = 1'b0;
        o_wr_addr    = {r_bank, r_len[AW-1:0]};
        o_wr_data    = r_held;
        if (accept) begin
            n_held       = i_byte;
            n_held_valid = 1'b1;
            if (r_held_valid) begin
                if (r_held == r_sync_first && i_byte == r_sync_second) begin
                    if (r_in_frame) begin
                        push    = 1'b1;
                        wr_bank = !r_bank;
                        n_bank  = !r_bank;
                    end
                    n_in_frame = 1'b1;
                    n_len      = LW'(1);
                    n_ovf      = 1'b0;
                    n_xor      = r_held;
                    o_wr_en    = 1'b1;
                    o_wr_addr  = {wr_bank, AW'(0)};
                end else if (r_in_frame) begin
                    n_xor = r_xor ^ r_held;
                    if (r_len < LW'(MAX_FRAME_BYTES)) begin
                        o_wr_en = 1'b1;
                        n_len   = r_len + LW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
        end
        n_q_valid = (r_q_valid && !i_q_pop) || push;
        n_q_desc  = r_q_desc;
        if (push) begin
            n_q_desc.status = status;
            n_q_desc.words  = words;
            n_q_desc.bank   = r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= 8'd0;
            r_sync_second <= 8'd0;
            r_held        <= 8'd0;
            r_held_valid  <= 1'b0;
            r_in_frame    <= 1'b0;
            r_len         <= '0;
            r_ovf         <= 1'b0;
            r_xor         <= 8'd0;
            r_bank        <= 1'b0;
            r_q_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                    default: ;
                endcase
            end
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_in_frame   <= n_in_frame;
            r_len        <= n_len;
            r_ovf        <= n_ovf;
            r_xor        <= n_xor;
            r_bank       <= n_bank;
            r_q_valid    <= n_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_desc <= n_q_desc;
    end

endmodule

// File: rtl/core/swdf_back.sv
module swdf_back #(
    parameter int MAX_FRAME_BYTES = swdf_pkg::MAX_FRAME_BYTES_DEF,
    parameter int AW              = $clog2(MAX_FRAME_BYTES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  swdf_pkg::t_desc      i_q_desc,
    output logic                 o_q_pop,
    output logic                 o_busy,
    output logic [AW:0]          o_rd_addr,
    input  logic [7:0]           i_rd_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [7:0]           o_command,
    output logic [15:0]          o_data_word,
    output logic                 o_word_valid,
    output logic [4:0]           o_word_index,
    output logic                 o_last
);
    import swdf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMD  = 5'b00010,
        S_HI   = 5'b00100,
        S_LO   = 5'b01000,
        S_EMIT = 5'b10000
    } t_back_state;

    t_back_state r_state, n_state;
    logic        r_bank, n_bank;
    logic [4:0]  r_words, n_words;
    logic [4:0]  r_idx, n_idx;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_hi, n_hi;
    t_status     r_st, n_st;
    logic [15:0] r_word, n_word;
    logic        r_wvalid, n_wvalid;
    logic        r_last, n_last;

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_o_status;
    logic [7:0]  r_o_cmd;
    logic [15:0] r_o_word;
    logic        r_o_wvalid;
    logic [4:0]  r_o_idx;
    logic        r_o_last;
    logic        load;

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_o_status;
    assign o_command    = r_o_cmd;
    assign o_data_word  = r_o_word;
    assign o_word_valid = r_o_wvalid;
    assign o_word_index = r_o_idx;
    assign o_last       = r_o_last;

    assign load = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state   = r_state;
        n_bank    = r_bank;
        n_words   = r_words;
        n_idx     = r_idx;
        n_ptr     = r_ptr;
        n_cmd     = r_cmd;
        n_hi      = r_hi;
        n_st      = r_st;
        n_word    = r_word;
        n_wvalid  = r_wvalid;
        n_last    = r_last;
        o_q_pop   = 1'b0;
        o_rd_addr = {r_bank, r_ptr};
        case (r_state)
            S_IDLE: begin
                o_rd_addr = {i_q_desc.bank, AW'(CMD_OFFSET)};
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_bank   = i_q_desc.bank;
                    n_words  = i_q_desc.words;
                    n_idx    = 5'd0;
                    n_ptr    = AW'(PAYLOAD_OFFSET);
                    n_st     = i_q_desc.status;
                    n_cmd    = 8'd0;
                    n_word   = 16'd0;
                    n_wvalid = 1'b0;
                    n_last   = 1'b1;
                    if (i_q_desc.status != ST_OK) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_CMD;
                    end
                end
            end
            S_CMD: begin
                n_cmd = i_rd_data;
                if (r_words == 5'd0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_HI;
                end
            end
            S_HI: begin
                n_hi      = i_rd_data;
                o_rd_addr = {r_bank, r_ptr + AW'(1)};
                n_state   = S_LO;
            end
            S_LO: begin
                n_word   = {r_hi, i_rd_data};
                n_wvalid = 1'b1;
                n_last   = (r_idx + 5'd1 == r_words);
                n_ptr    = r_ptr + AW'(2);
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (load) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 5'd1;
                        n_state = S_HI;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (r_out_valid && !i_ready) || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank   <= n_bank;
        r_words  <= n_words;
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_cmd    <= n_cmd;
        r_hi     <= n_hi;
        r_st     <= n_st;
        r_word   <= n_word;
        r_wvalid <= n_wvalid;
        r_last   <= n_last;
        if (load) begin
            r_o_status <= r_st;
            r_o_cmd    <= r_cmd;
            r_o_word   <= r_word;
            r_o_wvalid <= r_wvalid;
            r_o_idx    <= r_wvalid ? r_idx : 5'd0;
            r_o_last   <= r_last;
        end
    end

endmodule

// File: rtl/core/sync_word_xor_frame_deframer.sv
// Sync-word deframer with XOR check. Bytes enter on the s_ side one per request; a frame runs
// from one two-byte sync word (set by registers 0 and 1 on the config port) to the next and is
// written into one half of a double-banked byte store while its XOR, length and overflow are
// tracked. When the next sync word closes a frame, a descriptor goes through a one-entry queue
// to the drain engine, which emits one error result, or the command byte with each big-endian
// payload word (at most 30, last set on the final one), while new bytes keep filling the other
// bank. The input takes one byte per cycle; it stalls whenever the held byte inside a frame
// equals the first sync byte while the previous frame is still queued or draining. Draining
// goes straight to the result for an error frame; for a good frame the single read port of
// the store yields the command byte and then the high and low byte of each word in turn; a
// result waits in the output register while m_tready is low.
module sync_word_xor_frame_deframer #(
    parameter int MAX_FRAME_BYTES = swdf_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] command, [23:8] data_word, [28:24] word_index
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // [1:0] frame_status, [2] word_valid
);
    import swdf_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    logic        wr_en;
    logic [AW:0] wr_addr;
    logic [7:0]  wr_data;
    logic [AW:0] rd_addr;
    logic [7:0]  rd_data;
    logic        q_valid;
    t_desc       q_desc;
    logic        q_pop;
    logic        back_busy;
    logic [1:0]  status;
    logic [7:0]  command;
    logic [15:0] data_word;
    logic        word_valid;
    logic [4:0]  word_index;

    swdf_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .AW             (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_byte     (s_tdata),
        .i_back_busy(back_busy),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_q_valid  (q_valid),
        .o_q_desc   (q_desc),
        .i_q_pop    (q_pop)
    );

    swdf_store #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .AW             (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    swdf_back #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .AW             (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_desc    (q_desc),
        .o_q_pop     (q_pop),
        .o_busy      (back_busy),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_status    (status),
        .o_command   (command),
        .o_data_word (data_word),
        .o_word_valid(word_valid),
        .o_word_index(word_index),
        .o_last      (m_tlast)
    );

    assign m_tdata = {3'd0, word_index, data_word, command};
    assign m_tuser = {word_valid, status};

endmodule

// File: sim/sync_word_xor_frame_deframer_test.sv
module sync_word_xor_frame_deframer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import swdf_pkg::*;

    localparam int STORE_BYTES = MAX_FRAME_BYTES_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 40;
    localparam int WATCHDOG    = 3000;

    typedef struct packed {
        t_status     status;
        logic [7:0]  command;
        logic [15:0] data_word;
        logic        word_valid;
        logic [4:0]  word_index;
        logic        is_last;
    } t_frame_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = 1'b0;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata    = 8'h00;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    sync_word_xor_frame_deframer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0]    rx_q[$];
    t_frame_result want_results[$];
    int            queued_cnt = 0;
    int            taken_cnt  = 0;
    int            errors     = 0;
    int            cycle_cnt  = 0;
    int            quiet      = 0;
    int            hold_at    = -1;
    int            hold_left  = 0;
    int            send_idle  = 0;
    int            recv_idle  = 0;
    bit            rx_taken   = 1'b0;
    bit            result_taken = 1'b0;

    logic [7:0] sync_a = 8'h00;
    logic [7:0] sync_b = 8'h00;
    logic [7:0] held = 8'h00;
    bit         held_ok = 1'b0;
    bit         in_frame = 1'b0;
    int         frame_len = 0;
    bit         store_ovf = 1'b0;
    logic [7:0] frame_xor = 8'h00;
    logic [7:0] store[STORE_BYTES];

    function automatic void append_byte(input logic [7:0] b);
        frame_xor ^= b;
        if (frame_len < STORE_BYTES) begin
            store[frame_len] = b;
            frame_len++;
        end else begin
            store_ovf = 1'b1;
        end
    endfunction

    function automatic void close_frame();
        t_frame_result r;
        int n;
        int w;
        r = '0;
        r.is_last = 1'b1;
        if (store_ovf) r.status = ST_TOO_LONG;
        else if (frame_len < MIN_FRAME_BYTES) r.status = ST_TOO_SHORT;
        else if (frame_xor != 8'h00) r.status = ST_BAD_XOR;
        else r.status = ST_OK;
        if (r.status != ST_OK) begin
            want_results = {want_results, r};
            return;
        end
        r.command = store[CMD_OFFSET];
        n = (frame_len - MIN_FRAME_BYTES) / 2;
        if (n > MAX_WORDS) n = MAX_WORDS;
        if (n == 0) begin
            want_results = {want_results, r};
            return;
        end
        for (w = 0; w < n; w++) begin
            r.data_word  = {store[PAYLOAD_OFFSET + 2 * w], store[PAYLOAD_OFFSET + 2 * w + 1]};
            r.word_valid = 1'b1;
            r.word_index = w[4:0];
            r.is_last    = (w == n - 1);
            want_results = {want_results, r};
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        if (held_ok) begin
            if (held == sync_a && b == sync_b) begin
                if (in_frame && (frame_len > 0 || store_ovf)) close_frame();
                in_frame  = 1'b1;
                frame_len = 0;
                store_ovf = 1'b0;
                frame_xor = 8'h00;
                append_byte(held);
            end else if (in_frame) begin
                append_byte(held);
            end
        end
        held    = b;
        held_ok = 1'b1;
    endfunction

    function automatic string fmt(input t_frame_result r);
        return $sformatf("status=%0d cmd=%h word=%h valid=%b idx=%0d last=%b",
                         r.status, r.command, r.data_word, r.word_valid, r.word_index,
                         r.is_last);
    endfunction

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result exp_r;
        cycle_cnt++;
        rx_taken     = i_rst_n && s_tvalid && s_tready;
        result_taken = i_rst_n && m_tvalid && m_tready;
        if (rx_taken) begin
            deframe_byte(s_tdata);
            taken_cnt++;
        end
        if (result_taken) begin
            got.status     = t_status'(m_tuser[1:0]);
            got.word_valid = m_tuser[2];
            got.command    = m_tdata[7:0];
            got.data_word  = m_tdata[23:8];
            got.word_index = m_tdata[28:24];
            got.is_last    = m_tlast;
            if (want_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %s", fmt(got));
            end else begin
                exp_r = want_results[0];
                want_results.delete(0);
                if (got !== exp_r) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: expected %s", fmt(exp_r));
                        $display("          actual   %s", fmt(got));
                    end
                end
            end
        end
        if (rx_taken || result_taken || !i_rst_n) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG) begin
                $display("sync_word_xor_frame_deframer regression: fail");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || rx_taken) begin
            if (rx_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_tdata  <= rx_q[0];
                rx_q.delete(0);
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (cycle_cnt == hold_at) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic void queue_byte(input logic [7:0] b);
        rx_q = {rx_q, b};
        queued_cnt++;
    endfunction

    function automatic void queue_frame(input logic [7:0] cmd, input int npay,
                                        input bit bad_sum, input bit pattern);
        logic [7:0] sum;
        logic [7:0] b;
        int k;
        sum = sync_a ^ sync_b ^ cmd;
        queue_byte(sync_a);
        queue_byte(sync_b);
        queue_byte(cmd);
        for (k = 0; k < npay; k++) begin
            if (pattern) b = (k & 2) ? 8'h00 : 8'hFF;
            else b = 8'($urandom_range(255));
            sum ^= b;
            queue_byte(b);
        end
        if (bad_sum) sum ^= 8'($urandom_range(255, 1));
        queue_byte(sum);
    endfunction

    // mostly well-formed frames, some corrupt, short, or interrupted by noise
    function automatic void queue_random(input int nbytes);
        int stop_at;
        int k;
        stop_at = queued_cnt + nbytes;
        while (queued_cnt < stop_at) begin
            k = $urandom_range(99);
            if (k < 65) begin
                queue_frame(8'($urandom_range(255)), $urandom_range(12), 1'b0, 1'b0);
            end else if (k < 78) begin
                queue_frame(8'($urandom_range(255)), $urandom_range(12), 1'b1, 1'b0);
            end else if (k < 88) begin
                queue_byte(sync_a);
                queue_byte(sync_b);
                if ($urandom_range(1)) queue_byte(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(3, 1)) queue_byte(8'($urandom_range(255)));
            end
        end
    endfunction

    task automatic wait_drained();
        while (taken_cnt != queued_cnt || want_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic close_phase();
        queue_byte(sync_a);
        queue_byte(sync_b);
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SYNC_FIRST;
        i_cfg_data <= first;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SYNC_SECOND;
        i_cfg_data <= second;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sync_a = first;
        sync_b = second;
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 16;
        recv_idle = 53;
        set_sync(8'hA5, 8'h5A);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'hA5);
        queue_byte(8'h5A);
        queue_byte(8'h11);
        queue_frame(8'hFF, 0, 1'b0, 1'b0);
        queue_frame(8'h00, 5, 1'b0, 1'b1);
        queue_frame(8'h42, 2, 1'b1, 1'b0);
        hold_at = cycle_cnt + 8;
        queue_random(12);
        wait_drained();
        queue_random(6);
        close_phase();

        send_idle = 53;
        recv_idle = 16;
        set_sync(8'h00, 8'hFF);
        queue_random(10);
        close_phase();

        // overlapping sync pairs
        send_idle = 0;
        recv_idle = 0;
        set_sync(8'hFF, 8'hFF);
        repeat (4) queue_byte(8'hFF);
        queue_random(6);
        close_phase();

        set_sync(8'h00, 8'h00);
        queue_frame(8'($urandom_range(255)), STORE_BYTES - MIN_FRAME_BYTES, 1'b0, 1'b0);
        queue_frame(8'($urandom_range(255)), STORE_BYTES - MIN_FRAME_BYTES + 1, 1'b0, 1'b0);
        queue_byte(sync_a);
        queue_byte(sync_b);
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);

        if (errors == 0) begin
            $display("sync_word_xor_frame_deframer regression: pass");
        end else begin
            $display("sync_word_xor_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule
